### sv/rar_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rar_pkg
// Shared widths, payload types and controller/datapath interface structs for
// the rational add and reduce block.
// ----------------------------------------------------------------------------
package rar_pkg;

  localparam int IN_WIDTH = 16;
  localparam int PROD_W   = 2 * IN_WIDTH;
  localparam int NUM_W    = 2 * IN_WIDTH + 1;
  localparam int DEN_W    = 2 * IN_WIDTH - 1;
  localparam int CNT_W    = $clog2(PROD_W);
  localparam int SHIFT_W  = $clog2(PROD_W + 1);

  typedef struct packed {
    logic signed [IN_WIDTH-1:0] a_numerator;
    logic signed [IN_WIDTH-1:0] a_denominator;
    logic signed [IN_WIDTH-1:0] b_numerator;
    logic signed [IN_WIDTH-1:0] b_denominator;
  } in_item_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] sum_numerator;
    logic        [DEN_W-1:0] sum_denominator;
    logic                    zero_denominator_error;
  } out_item_t;

  typedef enum logic [1:0] {
    MUL_P1  = 2'd0,
    MUL_P2  = 2'd1,
    MUL_DEN = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     sum;
    logic     gcd_init;
    logic     shift_both;
    logic     shift_x;
    logic     gcd_step;
    logic     div_init;
    logic     div_step;
  } cmd_t;

  typedef struct packed {
    logic zero_den;
    logic num_zero;
    logic both_even;
    logic x_even;
    logic y_zero;
    logic div_last;
  } status_t;

endpackage

### sv/rational_add_reduce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_add_reduce
// Adds two signed fractions and reduces the sum to lowest terms.
// ----------------------------------------------------------------------------
// One item at a time: start is taken when busy is low, and the result beat
// appears on result with done high for exactly one cycle; the receiver cannot
// stall it, so it must take the beat in that cycle. An item with a zero
// denominator or a zero sum skips the gcd loop and the dividers. Otherwise
// the binary gcd loop, at one shift or subtract per cycle, and the 32-step
// restoring dividers set how long an item takes. The denominator is always
// positive and the sign sits on the numerator.
// ----------------------------------------------------------------------------
module rational_add_reduce (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  rar_pkg::in_item_t  operands,
  output logic               busy,
  output logic               done,
  output rar_pkg::out_item_t result
);

  rar_pkg::cmd_t    cmd;
  rar_pkg::status_t status;

  rar_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  rar_datapath u_datapath (
    .clk      (clk),
    .operands (operands),
    .cmd      (cmd),
    .status   (status),
    .result   (result)
  );

endmodule

### sv/rar_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rar_datapath
// Operand split, shared multiplier, signed sum, binary gcd registers and two
// restoring dividers that reduce numerator and denominator.
// ----------------------------------------------------------------------------
module rar_datapath (
  input  logic               clk,
  input  rar_pkg::in_item_t  operands,
  input  rar_pkg::cmd_t      cmd,
  output rar_pkg::status_t   status,
  output rar_pkg::out_item_t result
);

  localparam int W  = rar_pkg::IN_WIDTH;
  localparam int PW = rar_pkg::PROD_W;

  logic [W-1:0]  an, ad, bn, bd;
  logic          an_neg, ad_neg, bn_neg, bd_neg;
  logic [PW-1:0] p1, p2, dmag, nmag;
  logic          nneg;
  logic [PW-1:0] x, y;
  logic [rar_pkg::SHIFT_W-1:0] shift;
  logic [PW-1:0] g;
  logic [PW-1:0] rem_n, rem_d, q_n, q_d;
  logic [rar_pkg::CNT_W-1:0] cnt;

  logic [W-1:0]  mul_a, mul_b;
  logic [PW-1:0] product;
  logic          s1, s2;
  logic [PW:0]   trial_n, trial_d;
  logic          rneg;
  logic [rar_pkg::NUM_W-1:0] num_ext;

  function automatic logic [W-1:0] magnitude(input logic [W-1:0] v);
    magnitude = v[W-1] ? (~v + {{(W-1){1'b0}}, 1'b1}) : v;
  endfunction

  always_comb begin
    case (cmd.mul_sel)
      rar_pkg::MUL_P1: begin
        mul_a = an;
        mul_b = bd;
      end
      rar_pkg::MUL_P2: begin
        mul_a = bn;
        mul_b = ad;
      end
      default: begin
        mul_a = ad;
        mul_b = bd;
      end
    endcase
  end

  assign product = {{W{1'b0}}, mul_a} * {{W{1'b0}}, mul_b};

  assign s1 = (an_neg ^ bd_neg) && (p1 != '0);
  assign s2 = (bn_neg ^ ad_neg) && (p2 != '0);

  assign trial_n = {rem_n, q_n[PW-1]};
  assign trial_d = {rem_d, q_d[PW-1]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      an     <= magnitude(operands.a_numerator);
      ad     <= magnitude(operands.a_denominator);
      bn     <= magnitude(operands.b_numerator);
      bd     <= magnitude(operands.b_denominator);
      an_neg <= operands.a_numerator[W-1];
      ad_neg <= operands.a_denominator[W-1];
      bn_neg <= operands.b_numerator[W-1];
      bd_neg <= operands.b_denominator[W-1];
    end

    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        rar_pkg::MUL_P1: p1   <= product;
        rar_pkg::MUL_P2: p2   <= product;
        default:         dmag <= product;
      endcase
    end

    if (cmd.sum) begin
      if (s1 == s2) begin
        nmag <= p1 + p2;
        nneg <= s1;
      end else if (p1 >= p2) begin
        nmag <= p1 - p2;
        nneg <= s1;
      end else begin
        nmag <= p2 - p1;
        nneg <= s2;
      end
    end

    if (cmd.gcd_init) begin
      x     <= nmag;
      y     <= dmag;
      shift <= '0;
    end else if (cmd.shift_both) begin
      x     <= x >> 1;
      y     <= y >> 1;
      shift <= shift + 1'b1;
    end else if (cmd.shift_x) begin
      x <= x >> 1;
    end else if (cmd.gcd_step) begin
      // odd x: shift out the zeros of y first, else subtract the smaller
      if (!y[0]) begin
        y <= y >> 1;
      end else if (x > y) begin
        x <= y;
        y <= x - y;
      end else begin
        y <= y - x;
      end
    end

    if (cmd.div_init) begin
      g     <= x << shift;
      rem_n <= '0;
      rem_d <= '0;
      q_n   <= nmag;
      q_d   <= dmag;
      cnt   <= '0;
    end else if (cmd.div_step) begin
      cnt <= cnt + 1'b1;
      if (trial_n >= {1'b0, g}) begin
        rem_n <= PW'(trial_n - {1'b0, g});
        q_n   <= {q_n[PW-2:0], 1'b1};
      end else begin
        rem_n <= trial_n[PW-1:0];
        q_n   <= {q_n[PW-2:0], 1'b0};
      end
      if (trial_d >= {1'b0, g}) begin
        rem_d <= PW'(trial_d - {1'b0, g});
        q_d   <= {q_d[PW-2:0], 1'b1};
      end else begin
        rem_d <= trial_d[PW-1:0];
        q_d   <= {q_d[PW-2:0], 1'b0};
      end
    end
  end

  assign status.zero_den  = (ad == '0) || (bd == '0);
  assign status.num_zero  = (nmag == '0);
  assign status.both_even = !(x[0] | y[0]);
  assign status.x_even    = !x[0];
  assign status.y_zero    = (y == '0);
  assign status.div_last  = (cnt == rar_pkg::CNT_W'(PW - 1));

  // sign goes to the numerator
  assign rneg    = nneg ^ (ad_neg ^ bd_neg);
  assign num_ext = {1'b0, q_n};

  always_comb begin
    if (status.zero_den || status.num_zero) begin
      result.sum_numerator   = '0;
      result.sum_denominator = rar_pkg::DEN_W'(1);
    end else begin
      result.sum_numerator   = rneg ? (~num_ext + 1'b1) : num_ext;
      result.sum_denominator = q_d[rar_pkg::DEN_W-1:0];
    end
    result.zero_denominator_error = status.zero_den;
  end

endmodule

### sv/rar_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rar_ctrl
// Sequencer for the rational add and reduce block: multiplies, sum, binary gcd
// loop and divider iterations, then a one-cycle result beat.
// ----------------------------------------------------------------------------
module rar_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  rar_pkg::status_t status,
  output rar_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_MUL_A    = 12'b000000000010,
    S_MUL_B    = 12'b000000000100,
    S_MUL_D    = 12'b000000001000,
    S_SUM      = 12'b000000010000,
    S_CHECK    = 12'b000000100000,
    S_GCD_COM  = 12'b000001000000,
    S_GCD_XODD = 12'b000010000000,
    S_GCD_LOOP = 12'b000100000000,
    S_DIV_INIT = 12'b001000000000,
    S_DIV      = 12'b010000000000,
    S_DONE     = 12'b100000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_sel = rar_pkg::MUL_P1;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_MUL_A;
        end
      end
      S_MUL_A: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = rar_pkg::MUL_P1;
        state_next  = S_MUL_B;
      end
      S_MUL_B: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = rar_pkg::MUL_P2;
        state_next  = S_MUL_D;
      end
      S_MUL_D: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = rar_pkg::MUL_DEN;
        state_next  = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        // zero denominator or zero sum skips the reduction
        if (status.zero_den || status.num_zero) begin
          state_next = S_DONE;
        end else begin
          cmd.gcd_init = 1'b1;
          state_next   = S_GCD_COM;
        end
      end
      S_GCD_COM: begin
        if (status.both_even) begin
          cmd.shift_both = 1'b1;
        end else begin
          state_next = S_GCD_XODD;
        end
      end
      S_GCD_XODD: begin
        if (status.x_even) begin
          cmd.shift_x = 1'b1;
        end else begin
          state_next = S_GCD_LOOP;
        end
      end
      S_GCD_LOOP: begin
        if (status.y_zero) begin
          state_next = S_DIV_INIT;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule
